/* sv/touch_key_debounce_press_lockout_unit_macros.svh */
// Assertion macros shared by the touch key debounce unit.
// Expects clk and arst_n in scope at the point of use; no other dependencies.
`ifndef TOUCH_KEY_DEBOUNCE_PRESS_LOCKOUT_UNIT_MACROS_SVH
`define TOUCH_KEY_DEBOUNCE_PRESS_LOCKOUT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every edge outside reset.
`define TKD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("touch key unit: assertion failed");
// Condition in one cycle that implies a condition in the next cycle.
`define TKD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("touch key unit: assertion failed");
`else
`define TKD_ASSERT(label, prop)
`define TKD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* sv/tkd_pkg.sv */
// Types and constants for the touch key debounce and press lockout unit.
// No dependencies; every interface and module of the unit imports it.
package tkd_pkg;

	// Field widths of the scan and result beats and of the tick counters.
	localparam int unsigned MASK_W = 4;
	localparam int unsigned DBNC_W = 8;
	localparam int unsigned TICK_W = 16;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE_TICKS    = 2'd0,
		REG_SHORT_PRESS_TICKS = 2'd1,
		REG_LOCK_TICKS        = 2'd2
	} cfg_reg_t;

	localparam logic [DBNC_W-1:0] DEBOUNCE_RESET    = 8'd30;
	localparam logic [TICK_W-1:0] SHORT_PRESS_RESET = 16'd150;
	localparam logic [TICK_W-1:0] LOCK_RESET        = 16'd5000;

	localparam logic [DBNC_W-1:0] DBNC_MAX = {DBNC_W{1'b1}};
	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

	// Key phases.
	typedef enum logic [1:0] {
		PH_RELEASE  = 2'd0,
		PH_DEBOUNCE = 2'd1,
		PH_PRESS    = 2'd2
	} phase_t;

	// Configuration values seen by every lane.
	typedef struct packed {
		logic [DBNC_W-1:0] debounce_ticks;
		logic [TICK_W-1:0] short_press_ticks;
		logic [TICK_W-1:0] lock_ticks;
	} cfg_t;

	// Per-key status after the current tick.
	typedef struct packed {
		logic pending;
		logic evt;
		logic pressed;
	} lane_stat_t;

endpackage

/* sv/tkd_in_if.sv */
// Scan channel of the touch key unit: one beat per scan tick.
// Depends on tkd_pkg for field widths.
interface tkd_in_if;
	import tkd_pkg::*;

	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] touched_levels;
	logic [MASK_W-1:0] ack_mask;

	modport source (output valid, output touched_levels, output ack_mask, input ready);
	modport sink (input valid, input touched_levels, input ack_mask, output ready);
endinterface

/* sv/tkd_out_if.sv */
// Result channel of the touch key unit: one beat per accepted scan tick.
// Depends on tkd_pkg for field widths.
interface tkd_out_if;
	import tkd_pkg::*;

	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] pending_mask;
	logic [MASK_W-1:0] event_mask;
	logic [MASK_W-1:0] pressed_mask;
	logic              key0_locked;

	modport source (output valid, output pending_mask, output event_mask,
		output pressed_mask, output key0_locked, input ready);
	modport sink (input valid, input pending_mask, input event_mask,
		input pressed_mask, input key0_locked, output ready);
endinterface

/* sv/tkd_lane.sv */
// One key lane: release, debounce and press phases, held time and event flags.
// Depends on tkd_pkg and the unit's assertion macro header.
`include "touch_key_debounce_press_lockout_unit_macros.svh"

module tkd_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                touched,
	input  logic                ack,
	input  logic                frozen,
	input  tkd_pkg::cfg_t       cfg,
	output tkd_pkg::lane_stat_t stat_d
);
	import tkd_pkg::*;

	phase_t            phase_q, phase_d;
	logic [DBNC_W-1:0] dcnt_q, dcnt_d, dcnt_inc;
	logic [TICK_W-1:0] held_q, held_d;
	logic              evt_q, evt_d, pend_q, pend_d;
	logic              ack_hit, pend_a, evt_a, short_hit;

	// Acknowledge is applied before the phase update.
	assign ack_hit  = ack && pend_q && evt_q;
	assign pend_a   = pend_q && !ack_hit;
	assign evt_a    = evt_q && !ack_hit;
	assign dcnt_inc = (dcnt_q < DBNC_MAX) ? dcnt_q + 1'b1 : dcnt_q;
	assign short_hit = (held_q >= cfg.short_press_ticks) && !pend_a;

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (frozen) begin
			if (phase_q == PH_PRESS && !touched) begin
				phase_d = PH_RELEASE;
			end
		end else begin
			case (phase_q)
				PH_RELEASE: begin
					if (touched) begin
						phase_d = PH_DEBOUNCE;
					end
				end
				PH_DEBOUNCE: begin
					if (!touched) begin
						phase_d = PH_RELEASE;
					end else if (dcnt_inc >= cfg.debounce_ticks) begin
						phase_d = PH_PRESS;
					end
				end
				PH_PRESS: begin
					if (!touched) begin
						phase_d = PH_DEBOUNCE;
					end
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// Counters and flags for the tick.
	always_comb begin
		dcnt_d = dcnt_q;
		held_d = held_q;
		evt_d  = evt_a;
		pend_d = pend_a;
		if (frozen) begin
			if (phase_q == PH_PRESS && !touched) begin
				held_d = '0;
			end
		end else begin
			case (phase_q)
				PH_RELEASE: begin
					if (touched) begin
						dcnt_d = '0;
					end
					held_d = '0;
					evt_d  = 1'b0;
				end
				PH_DEBOUNCE: begin
					if (!touched || dcnt_inc >= cfg.debounce_ticks) begin
						dcnt_d = '0;
					end else begin
						dcnt_d = dcnt_inc;
					end
				end
				PH_PRESS: begin
					if (touched) begin
						if (held_q < TICK_MAX) begin
							held_d = held_q + 1'b1;
						end
					end else begin
						dcnt_d = '0;
						if (short_hit) begin
							evt_d  = 1'b1;
							pend_d = 1'b1;
						end
					end
				end
				default: dcnt_d = dcnt_q;
			endcase
		end
	end

	assign stat_d.pending = pend_d;
	assign stat_d.evt     = evt_d;
	assign stat_d.pressed = (phase_d == PH_PRESS);

	// Lane state advances once per accepted scan beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RELEASE;
			dcnt_q  <= '0;
			held_q  <= '0;
			evt_q   <= 1'b0;
			pend_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			dcnt_q  <= dcnt_d;
			held_q  <= held_d;
			evt_q   <= evt_d;
			pend_q  <= pend_d;
		end
	end

	// An event flag never stands without its pending flag.
	`TKD_ASSERT(a_evt_needs_pend, (!evt_q || pend_q))
	// The debounce count is cleared whenever a press is confirmed.
	`TKD_ASSERT(a_press_dcnt_zero, (phase_q != PH_PRESS || dcnt_q == '0))
endmodule

/* sv/tkd_lock.sv */
// Lockout timer for key 0, armed by a pending event on that key.
// Depends on tkd_pkg and the unit's assertion macro header.
`include "touch_key_debounce_press_lockout_unit_macros.svh"

module tkd_lock (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [tkd_pkg::TICK_W-1:0]  lock_ticks,
	input  logic                        pend0_d,
	output logic                        frozen,
	output logic                        locked_d
);
	import tkd_pkg::*;

	logic              lock_q, lock_t;
	logic [TICK_W-1:0] cnt_q, cnt_t, cnt_d, cnt_inc;
	logic              arm;

	// Timer runs first in the tick; its result freezes key 0.
	assign cnt_inc = (cnt_q < TICK_MAX) ? cnt_q + 1'b1 : cnt_q;
	always_comb begin
		lock_t = lock_q;
		cnt_t  = cnt_q;
		if (lock_q) begin
			if (cnt_inc >= lock_ticks) begin
				lock_t = 1'b0;
				cnt_t  = '0;
			end else begin
				cnt_t = cnt_inc;
			end
		end
	end

	assign frozen = lock_t;

	// A pending event on a key 0 that was free this tick re-arms the lock.
	assign arm      = !lock_t && pend0_d;
	assign locked_d = lock_t || arm;
	assign cnt_d    = arm ? '0 : cnt_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q <= 1'b0;
			cnt_q  <= '0;
		end else if (step) begin
			lock_q <= locked_d;
			cnt_q  <= cnt_d;
		end
	end

	// The count only runs while the lock is held.
	`TKD_ASSERT(a_idle_cnt_zero, (lock_q || cnt_q == '0))
	// Arming always leaves the lock set with a fresh count.
	`TKD_ASSERT_NEXT(a_arm_sets_lock, step && arm, lock_q && cnt_q == '0)
endmodule

/* sv/touch_key_debounce_press_lockout_unit.sv */
// Channel   Dir  Beat contents                                        Accept
// scan      in   touched_levels[3:0], ack_mask[3:0]                   valid && ready
// result    out  pending_mask, event_mask, pressed_mask, key0_locked   valid && ready
// cfg       in   cfg_index, cfg_wdata                                  cfg_we
//
// One scan beat per clock while scan.ready is high; each accepted beat gives one result beat in the next cycle.
// All key lanes and the key 0 lock timer update in the same cycle, so the rate is
// set only by the single output register: scan.ready drops only while a result waits.
// Reset (arst_n low) puts every key in release, clears flags and the lock timer,
// and loads the register defaults; no clearing pass is needed.
// Top level: configuration registers, key lanes, lock timer and the merging stage.
// Depends on tkd_pkg, tkd_in_if, tkd_out_if, tkd_lane, tkd_lock and the macro header.
`include "touch_key_debounce_press_lockout_unit_macros.svh"

module touch_key_debounce_press_lockout_unit #(
	parameter int unsigned NUM_KEYS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tkd_in_if.sink                         scan,
	tkd_out_if.source                      result,
	input  logic                           cfg_we,
	input  logic [tkd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tkd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import tkd_pkg::*;

	cfg_t              cfg_q;
	logic              step;
	logic              frozen, locked_d;
	lane_stat_t        stat_d [NUM_KEYS];
	logic [MASK_W-1:0] pend_m, evt_m, prs_m;
	logic              out_valid_q;
	logic [MASK_W-1:0] pend_q, evt_q, prs_q;
	logic              locked_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks    <= DEBOUNCE_RESET;
			cfg_q.short_press_ticks <= SHORT_PRESS_RESET;
			cfg_q.lock_ticks        <= LOCK_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DEBOUNCE_TICKS:    cfg_q.debounce_ticks    <= cfg_wdata[DBNC_W-1:0];
				REG_SHORT_PRESS_TICKS: cfg_q.short_press_ticks <= cfg_wdata[TICK_W-1:0];
				REG_LOCK_TICKS:        cfg_q.lock_ticks        <= cfg_wdata[TICK_W-1:0];
				default:               cfg_q                   <= cfg_q;
			endcase
		end
	end

	assign scan.ready = !out_valid_q || result.ready;
	assign step       = scan.valid && scan.ready;

	// Lock timer for key 0.
	tkd_lock u_lock (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.lock_ticks (cfg_q.lock_ticks),
		.pend0_d    (stat_d[0].pending),
		.frozen     (frozen),
		.locked_d   (locked_d)
	);

	// Key lanes; keys beyond the field width read untouched and unacknowledged.
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		logic t_k, a_k, f_k;
		if (k < MASK_W) begin : g_field
			assign t_k = scan.touched_levels[k];
			assign a_k = scan.ack_mask[k];
		end else begin : g_nofield
			assign t_k = 1'b0;
			assign a_k = 1'b0;
		end
		if (k == 0) begin : g_key0
			assign f_k = frozen;
		end else begin : g_free
			assign f_k = 1'b0;
		end
		tkd_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (step),
			.touched (t_k),
			.ack     (a_k),
			.frozen  (f_k),
			.cfg     (cfg_q),
			.stat_d  (stat_d[k])
		);
	end

	// Merge lane status into the result masks.
	for (genvar b = 0; b < MASK_W; b++) begin : g_merge
		if (b < NUM_KEYS) begin : g_have
			assign pend_m[b] = stat_d[b].pending;
			assign evt_m[b]  = stat_d[b].evt;
			assign prs_m[b]  = stat_d[b].pressed;
		end else begin : g_none
			assign pend_m[b] = 1'b0;
			assign evt_m[b]  = 1'b0;
			assign prs_m[b]  = 1'b0;
		end
	end

	// Output register: holds a result beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			pend_q   <= pend_m;
			evt_q    <= evt_m;
			prs_q    <= prs_m;
			locked_q <= locked_d;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.pending_mask = pend_q;
	assign result.event_mask   = evt_q;
	assign result.pressed_mask = prs_q;
	assign result.key0_locked  = locked_q;

	// Scan beats stall only behind a result that is waiting.
	`TKD_ASSERT(a_stall_cause, (scan.ready || (out_valid_q && !result.ready)))
	// An accepted scan beat always yields a result beat next cycle.
	`TKD_ASSERT_NEXT(a_step_result, step, out_valid_q)
endmodule
